FILE: rtl/tty_line_discipline_buffer_assert.svh
// Assertion helpers used by the line buffer back end.
`ifndef TTY_LINE_DISCIPLINE_BUFFER_ASSERT_SVH
`define TTY_LINE_DISCIPLINE_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TLDB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tldb check failed");

// Next-cycle implication, disabled during reset.
`define TLDB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tldb check failed");

`endif

FILE: rtl/tldb_pkg.sv
package tldb_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 64;

   // request opcodes
   localparam logic [1:0] OPC_KEY  = 2'd0;
   localparam logic [1:0] OPC_READ = 2'd1;
   localparam logic [1:0] OPC_DUMP = 2'd2;

   // control characters
   localparam logic [7:0] CH_ETX = 8'd3;
   localparam logic [7:0] CH_EOT = 8'd4;
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_NL  = 8'd10;

   localparam logic [6:0] MAX_READ = 7'd64;

   // result kinds
   localparam logic [3:0] KIND_IGNORED   = 4'd0;
   localparam logic [3:0] KIND_ECHO_CHAR = 4'd1;
   localparam logic [3:0] KIND_ECHO_NL   = 4'd2;
   localparam logic [3:0] KIND_ECHO_BS   = 4'd3;
   localparam logic [3:0] KIND_READ      = 4'd4;
   localparam logic [3:0] KIND_EOF       = 4'd5;
   localparam logic [3:0] KIND_NONE      = 4'd6;
   localparam logic [3:0] KIND_RAW       = 4'd7;
   localparam logic [3:0] KIND_RAW_EMPTY = 4'd8;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] key_byte;
      logic [6:0] max_count;
   } req_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] data_byte;
      logic [6:0] byte_count;
      logic       line_ready;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_KEY,
      CMD_READ,
      CMD_DUMP,
      CMD_NOP
   } cmd_op_type;

   typedef enum logic [2:0] {
      KEY_ORD,
      KEY_EOT,
      KEY_NL,
      KEY_ETX,
      KEY_BS
   } key_class_type;

   // classified command handed from front to back
   typedef struct packed {
      cmd_op_type    op;
      key_class_type key_class;
      logic [7:0]    key_byte;
      logic [6:0]    limit;
   } cmd_type;

endpackage

FILE: rtl/tldb_front.sv
module tldb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  tldb_pkg::req_type req_item,
   output logic              busy,
   output logic              cmd_valid,
   output tldb_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   tldb_pkg::cmd_type q_ff [2];
   tldb_pkg::cmd_type cls;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;
   logic              pop;

   // classify the request
   always_comb begin
      cls.key_byte = req_item.key_byte;
      case (req_item.opcode)
         tldb_pkg::OPC_KEY:  cls.op = tldb_pkg::CMD_KEY;
         tldb_pkg::OPC_READ: cls.op = tldb_pkg::CMD_READ;
         tldb_pkg::OPC_DUMP: cls.op = tldb_pkg::CMD_DUMP;
         default:            cls.op = tldb_pkg::CMD_NOP;
      endcase
      case (req_item.key_byte)
         tldb_pkg::CH_EOT: cls.key_class = tldb_pkg::KEY_EOT;
         tldb_pkg::CH_NL:  cls.key_class = tldb_pkg::KEY_NL;
         tldb_pkg::CH_ETX: cls.key_class = tldb_pkg::KEY_ETX;
         tldb_pkg::CH_BS:  cls.key_class = tldb_pkg::KEY_BS;
         default:          cls.key_class = tldb_pkg::KEY_ORD;
      endcase
      // clamp the read count to 1..64
      if (req_item.max_count == 7'd0) begin
         cls.limit = 7'd1;
      end else if (req_item.max_count > tldb_pkg::MAX_READ) begin
         cls.limit = tldb_pkg::MAX_READ;
      end else begin
         cls.limit = req_item.max_count;
      end
   end

   assign busy      = (cnt_ff == 2'd2);
   assign push      = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

FILE: rtl/tldb_back.sv
module tldb_back #(
   parameter int BUFFER_DEPTH = tldb_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tldb_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   output tldb_pkg::rsp_type rsp_item
);

   `include "tty_line_discipline_buffer_assert.svh"

   localparam int PTR_W = $clog2(BUFFER_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DUMP = 3'b100
   } back_state_type;

   function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_ret(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == '0) ? PTR_W'(BUFFER_DEPTH - 1) : p - PTR_W'(1);
      return r;
   endfunction

   logic [7:0]        mem [BUFFER_DEPTH];
   back_state_type    state_ff, state_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [PTR_W-1:0]  cp_ff, cp_in;
   logic              full_ff, full_in;
   logic [PTR_W-1:0]  scan_ff, scan_in;
   logic [6:0]        count_ff, count_in;
   logic [6:0]        limit_ff, limit_in;
   logic [7:0]        rd_data_ff;
   logic [PTR_W-1:0]  rd_addr;
   logic              we;
   logic              rsp_valid_ff, rsp_valid_in;
   tldb_pkg::rsp_type rsp_ff, rsp_in;
   logic [PTR_W-1:0]  wp_adv, rp_adv, scan_adv;
   logic [6:0]        cnt_inc;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cp_in        = cp_ff;
      full_in      = full_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      we           = 1'b0;
      cmd_pop      = 1'b0;
      rd_addr      = cp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wp_adv       = ptr_adv(wp_ff);
      rp_adv       = ptr_adv(rp_ff);
      scan_adv     = ptr_adv(scan_ff);
      cnt_inc      = count_ff + 7'd1;

      case (state_ff)
         ST_IDLE: begin
            if (cmd.op == tldb_pkg::CMD_READ) begin
               rd_addr = rp_ff;
            end
            if (cmd_valid) begin
               cmd_pop        = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_in.last    = 1'b1;
               case (cmd.op)
                  tldb_pkg::CMD_KEY: begin
                     if (full_ff) begin
                        rsp_in.kind = tldb_pkg::KIND_IGNORED;
                     end else begin
                        case (cmd.key_class)
                           tldb_pkg::KEY_EOT, tldb_pkg::KEY_NL: begin
                              we                = 1'b1;
                              wp_in             = wp_adv;
                              cp_in             = wp_adv;
                              full_in           = (wp_adv == rp_ff);
                              rsp_in.line_ready = 1'b1;
                              if (cmd.key_class == tldb_pkg::KEY_NL) begin
                                 rsp_in.kind      = tldb_pkg::KIND_ECHO_NL;
                                 rsp_in.data_byte = tldb_pkg::CH_NL;
                              end
                           end
                           tldb_pkg::KEY_ETX: begin
                              wp_in            = cp_ff;
                              rsp_in.kind      = tldb_pkg::KIND_ECHO_NL;
                              rsp_in.data_byte = tldb_pkg::CH_NL;
                           end
                           tldb_pkg::KEY_BS: begin
                              if (wp_ff != cp_ff) begin
                                 wp_in            = ptr_ret(wp_ff);
                                 rsp_in.kind      = tldb_pkg::KIND_ECHO_BS;
                                 rsp_in.data_byte = tldb_pkg::CH_BS;
                              end
                           end
                           default: begin
                              // ordinary byte needs two free slots
                              if (wp_adv != rp_ff) begin
                                 we               = 1'b1;
                                 wp_in            = wp_adv;
                                 rsp_in.kind      = tldb_pkg::KIND_ECHO_CHAR;
                                 rsp_in.data_byte = cmd.key_byte;
                              end
                           end
                        endcase
                     end
                  end
                  tldb_pkg::CMD_READ: begin
                     if (rp_ff == cp_ff && !full_ff) begin
                        rsp_in.kind = tldb_pkg::KIND_NONE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        count_in     = 7'd0;
                        limit_in     = cmd.limit;
                        state_in     = ST_READ;
                     end
                  end
                  tldb_pkg::CMD_DUMP: begin
                     if (cp_ff == wp_ff) begin
                        rsp_in.kind = tldb_pkg::KIND_RAW_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        scan_in      = cp_ff;
                        count_in     = 7'd0;
                        state_in     = ST_DUMP;
                     end
                  end
                  default: begin
                     rsp_in.kind = tldb_pkg::KIND_IGNORED;
                  end
               endcase
            end
         end
         ST_READ: begin
            // rd_data_ff holds the byte at rp_ff; next address prefetched
            rd_addr      = rp_adv;
            rp_in        = rp_adv;
            full_in      = 1'b0;
            rsp_valid_in = 1'b1;
            if (rd_data_ff == tldb_pkg::CH_EOT) begin
               rsp_in.kind       = tldb_pkg::KIND_EOF;
               rsp_in.byte_count = count_ff;
               rsp_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               rsp_in.kind       = tldb_pkg::KIND_READ;
               rsp_in.data_byte  = rd_data_ff;
               rsp_in.byte_count = cnt_inc;
               count_in          = cnt_inc;
               if (rd_data_ff == tldb_pkg::CH_NL || cnt_inc == limit_ff ||
                   rp_adv == cp_ff) begin
                  rsp_in.last = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_DUMP: begin
            rd_addr           = scan_adv;
            scan_in           = scan_adv;
            count_in          = cnt_inc;
            rsp_valid_in      = 1'b1;
            rsp_in.kind       = tldb_pkg::KIND_RAW;
            rsp_in.data_byte  = rd_data_ff;
            rsp_in.byte_count = cnt_inc;
            if (scan_adv == wp_ff) begin
               rsp_in.last = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cp_ff        <= '0;
         full_ff      <= 1'b0;
         scan_ff      <= '0;
         count_ff     <= 7'd0;
         limit_ff     <= 7'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cp_ff        <= cp_in;
         full_ff      <= full_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wp_ff] <= cmd.key_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `TLDB_ASSERT_IMP(a_full_ptrs, clock, reset, full_ff, (wp_ff == rp_ff) && (cp_ff == wp_ff))
   `TLDB_ASSERT_IMP(a_no_pop_busy, clock, reset, state_ff != ST_IDLE, !cmd_pop)
   `TLDB_ASSERT_NXT(a_read_streams, clock, reset, state_ff == ST_READ, rsp_valid_ff)

endmodule

FILE: rtl/tty_line_discipline_buffer.sv
// Timing: with the back end idle, a key press is queued in the front end and its
//   result is registered in the back end; a read or dump first loads the store's
//   read register, then strobes one result per cycle until its last byte.
// Throughput: one key press per cycle while busy is low; a read or dump holds the
//   back end until its last byte, set by the single registered read port of the store.
// Reset (synchronous, active high) empties the queue and clears pointers and the
//   full flag; store contents are kept. Results cannot be stalled by the receiver.
module tty_line_discipline_buffer #(
   parameter int BUFFER_DEPTH = tldb_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  tldb_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_valid,
   output tldb_pkg::rsp_type rsp_item
);

   // Front end: decodes opcode and key class, clamps the read count and
   // parks the item in a two-entry queue. busy only rises when that queue
   // is full, so items keep arriving while the back end streams a read.
   logic              cmd_valid;
   logic              cmd_pop;
   tldb_pkg::cmd_type cmd;

   tldb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Back end: owns the circular line store and the read, cooked and write
   // pointers. Key presses complete in the cycle they are popped; reads and
   // dumps walk the store one byte per cycle with the next address prefetched.
   tldb_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
